[design/modinv_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// modinv_pkg
// Shared types for the modular inverse block: the sequencer state encoding.
// ============================================================================
package modinv_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ALIGN,
    ST_SUB,
    ST_SWAP,
    ST_FIX,
    ST_DONE
  } state_e;

endpackage

[design/modinv_in_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// modinv_in_if
// Request channel of the modular inverse block: a value and its modulus.
// ============================================================================
interface modinv_in_if #(
  parameter int unsigned W = 31
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] value;
  logic [W-1:0] modulus;

  modport source (output valid, output value, output modulus, input ready);
  modport sink   (input valid, input value, input modulus, output ready);
endinterface

[design/modinv_out_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// modinv_out_if
// Result channel of the modular inverse block: the inverse and a found flag.
// ============================================================================
interface modinv_out_if #(
  parameter int unsigned W = 31
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] inverse;
  logic         found;

  modport source (output valid, output inverse, output found, input ready);
  modport sink   (input valid, input inverse, input found, output ready);
endinterface

[design/modular_inverse_ext_euclid.sv]
`timescale 1ns / 1ps
// ============================================================================
// modular_inverse_ext_euclid
// Modular inverse by the extended Euclidean algorithm on one shared
// compare/subtract unit under a small sequencer.
// ============================================================================
// Usage:
//   in_i carries one item (value, modulus) under a valid/ready handshake.
//   out_o returns one item per request: inverse in [0, modulus) and found,
//   which is set when gcd(value, modulus) is one. Without an inverse, both
//   fields read zero. A modulus of one gives inverse zero with found set.
//   Each Euclid quotient is found by shift-and-subtract long division: the
//   divisor is shifted up one bit a cycle until it is aligned with the
//   remainder, then one quotient bit is resolved per cycle while the value
//   coefficient is updated alongside. The time an item takes from
//   acceptance to a valid result grows with the number of Euclid steps
//   and the sizes of their quotients, so it is data dependent.
//   in_i.ready is high only while the sequencer is idle. The result sits in
//   an output register, so a stalled receiver blocks only the hand-over of
//   the following result; the next item can be accepted and worked on.
//   Reset clears the sequencer and the output valid flag.
// ============================================================================
module modular_inverse_ext_euclid #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  modinv_in_if.sink           in_i,
  modinv_out_if.source        out_o
);

  localparam int unsigned SW = VALUE_BITS + 1;
  localparam int unsigned KW = $clog2(VALUE_BITS);

  modinv_pkg::state_e state_q, state_d;

  logic [VALUE_BITS-1:0]        r0_q, r0_d;
  logic [VALUE_BITS-1:0]        r1_q, r1_d;
  logic [VALUE_BITS-1:0]        d_q, d_d;
  logic [VALUE_BITS-1:0]        mod_q, mod_d;
  logic signed [SW-1:0]         s0_q, s0_d;
  logic signed [SW-1:0]         s1_q, s1_d;
  logic signed [SW-1:0]         e_q, e_d;
  logic [KW-1:0]                k_q, k_d;
  logic                         out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0]        out_inverse_q, out_inverse_d;
  logic                         out_found_q, out_found_d;

  logic                         in_accept;
  logic                         out_free;
  logic                         align_go;
  logic                         sub_go;
  logic                         found_w;
  logic [VALUE_BITS-1:0]        x_w;

  assign in_i.ready    = (state_q == modinv_pkg::ST_IDLE);
  assign in_accept     = in_i.valid && in_i.ready;
  assign out_free      = !out_valid_q || out_o.ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.inverse = out_inverse_q;
  assign out_o.found   = out_found_q;

  // Keep doubling the divisor while twice its value still fits under the
  // remainder; this never overflows since the remainder has VALUE_BITS bits.
  assign align_go = ({d_q, 1'b0} <= {1'b0, r0_q});
  assign sub_go   = (r0_q >= d_q);
  // A zero modulus never has an inverse, whatever the value.
  assign found_w  = (r0_q == VALUE_BITS'(1)) && (mod_q != '0);
  assign x_w      = s0_q[VALUE_BITS-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      modinv_pkg::ST_IDLE: begin
        if (in_accept) state_d = modinv_pkg::ST_CHECK;
      end
      modinv_pkg::ST_CHECK: begin
        if (r1_q == '0) state_d = modinv_pkg::ST_FIX;
        else            state_d = modinv_pkg::ST_ALIGN;
      end
      modinv_pkg::ST_ALIGN: begin
        if (!align_go) state_d = modinv_pkg::ST_SUB;
      end
      modinv_pkg::ST_SUB: begin
        if (k_q == '0) state_d = modinv_pkg::ST_SWAP;
      end
      modinv_pkg::ST_SWAP: state_d = modinv_pkg::ST_CHECK;
      modinv_pkg::ST_FIX:  state_d = modinv_pkg::ST_DONE;
      modinv_pkg::ST_DONE: begin
        if (out_free) state_d = modinv_pkg::ST_IDLE;
      end
      default: state_d = modinv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    r0_d          = r0_q;
    r1_d          = r1_q;
    d_d           = d_q;
    mod_d         = mod_q;
    s0_d          = s0_q;
    s1_d          = s1_q;
    e_d           = e_q;
    k_d           = k_q;
    out_inverse_d = out_inverse_q;
    out_found_d   = out_found_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    case (state_q)
      modinv_pkg::ST_IDLE: begin
        if (in_accept) begin
          r0_d  = in_i.value;
          r1_d  = in_i.modulus;
          mod_d = in_i.modulus;
          s0_d  = SW'(1);
          s1_d  = '0;
        end
      end
      modinv_pkg::ST_CHECK: begin
        d_d = r1_q;
        e_d = s1_q;
        k_d = '0;
      end
      modinv_pkg::ST_ALIGN: begin
        if (align_go) begin
          d_d = {d_q[VALUE_BITS-2:0], 1'b0};
          e_d = e_q <<< 1;
          k_d = k_q + KW'(1);
        end
      end
      modinv_pkg::ST_SUB: begin
        // One quotient bit: the remainder and the value coefficient are
        // reduced by the shifted divisor and the shifted coefficient.
        if (sub_go) begin
          r0_d = r0_q - d_q;
          s0_d = s0_q - e_q;
        end
        if (k_q != '0) begin
          d_d = d_q >> 1;
          e_d = e_q >>> 1;
          k_d = k_q - KW'(1);
        end
      end
      modinv_pkg::ST_SWAP: begin
        r0_d = r1_q;
        r1_d = r0_q;
        s0_d = s1_q;
        s1_d = s0_q;
      end
      modinv_pkg::ST_FIX: begin
        if (s0_q[SW-1]) s0_d = s0_q + $signed({1'b0, mod_q});
      end
      modinv_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_found_d = found_w;
          if (!found_w)         out_inverse_d = '0;
          else if (x_w >= mod_q) out_inverse_d = x_w - mod_q;
          else                  out_inverse_d = x_w;
        end
      end
      default: begin
        out_valid_d = out_valid_q && !out_o.ready;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= modinv_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q          <= r0_d;
    r1_q          <= r1_d;
    d_q           <= d_d;
    mod_q         <= mod_d;
    s0_q          <= s0_d;
    s1_q          <= s1_d;
    e_q           <= e_d;
    k_q           <= k_d;
    out_inverse_q <= out_inverse_d;
    out_found_q   <= out_found_d;
  end

  // The divisor is never zero while quotient bits are resolved.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == modinv_pkg::ST_SUB |-> d_q != '0)
    else $error("divisor is zero during subtraction");

  // Long division leaves a remainder below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == modinv_pkg::ST_SWAP |-> r0_q < r1_q)
    else $error("remainder not below divisor after division");

  // A result without an inverse carries a zero inverse.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_found_q |-> out_inverse_q == '0)
    else $error("nonzero inverse reported without found");

  // Once the result is loaded the sequencer is free for the next item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == modinv_pkg::ST_DONE && out_free |=>
      state_q == modinv_pkg::ST_IDLE && out_valid_q)
    else $error("result hand-over did not complete");

endmodule
